[sv/qts_pkg.sv]
// ----------------------------------------------------------------------------
// Queue from two stacks: shared package
// Widths, operation and status codes, and the command and result records
// that pass between the front and back parts of the block.
// ----------------------------------------------------------------------------
`default_nettype none

package qts_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int FILL_W     = $clog2(DEPTH + 1);
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 6;
    localparam int LIMIT_W    = 5;

    localparam int IN_TDATA_W  = ((FUNC_W + DATA_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((STATUS_W + DATA_WIDTH + COUNT_W + 7) / 8) * 8;

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;
    localparam logic REG_STACK_LIMIT = 1'b0;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SIZE   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SIZE   = 2'd2
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [DATA_WIDTH-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [COUNT_W-1:0]    count;
        logic [DATA_WIDTH-1:0] value;
        logic [STATUS_W-1:0]   status;
    } result_t;

endpackage

`default_nettype wire

[sv/queue_from_two_stacks.sv]
// ----------------------------------------------------------------------------
// Queue from two stacks: top level
// A first-in first-out queue of 32-bit elements built from two bounded
// stacks, with insert, remove and size query operations.
//
// Each input transaction on s_t* carries func in s_tdata[1:0] and value_in
// in s_tdata[33:2]. Each one yields exactly one output transaction on m_t*
// with status in m_tdata[1:0], value_out in m_tdata[33:2] and the combined
// element count in m_tdata[39:34]. The APB register at byte address 0 holds
// stack_limit, the most elements the insertion stack may hold.
// Inserts, failed operations and size queries pass through the command
// queue and the result register; a successful remove also passes through
// the pop state, which reads the deletion store. An operation that first
// moves n elements across moves one element per cycle through the
// insertion store read port. The block takes one operation per cycle while
// results are accepted and no remove or transfer runs. Reset empties both
// stacks and sets stack_limit to 16. A stalled receiver holds the result
// register; a two-entry command queue keeps accepting until it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module queue_from_two_stacks (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Fields from bit 0: func, value_in.
    input  wire logic [qts_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // Fields from bit 0: status, value_out, count.
    output logic      [qts_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [qts_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [qts_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [qts_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                 pready
);

    logic [qts_pkg::LIMIT_W-1:0] limit_reg, limit_next;
    logic                        reg_sel;
    logic                        cmd_valid;
    logic                        cmd_ready;
    qts_pkg::cmd_t               cmd;
    qts_pkg::result_t            res;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[qts_pkg::CFG_ADDR_W-1] == qts_pkg::REG_STACK_LIMIT);
    assign prdata  = reg_sel ? qts_pkg::CFG_DATA_W'(limit_reg) : '0;

    always_comb begin
        limit_next = limit_reg;
        if (psel && penable && pwrite && pready && reg_sel) begin
            limit_next = pwdata[qts_pkg::LIMIT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= qts_pkg::LIMIT_RESET;
        end else begin
            limit_reg <= limit_next;
        end
    end

    qts_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    qts_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .stack_limit (limit_reg),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res         (res)
    );

    assign m_tdata = qts_pkg::OUT_TDATA_W'(res);

endmodule

`default_nettype wire

[sv/qts_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module qts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[sv/qts_front.sv]
// ----------------------------------------------------------------------------
// Queue from two stacks: front part
// Accepts input transactions, decodes the operation and holds the commands
// in a two-entry queue until the back part takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module qts_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [qts_pkg::IN_TDATA_W-1:0] s_tdata,
    output logic                                cmd_valid,
    input  wire logic                           cmd_ready,
    output qts_pkg::cmd_t                       cmd
);

    qts_pkg::cmd_t                      entry_reg [qts_pkg::CMDQ_DEPTH];
    logic [qts_pkg::CMDQ_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [qts_pkg::CMDQ_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [qts_pkg::CMDQ_CNT_W-1:0]     cnt_reg, cnt_next;
    logic                               push, pop;
    logic [qts_pkg::FUNC_W-1:0]         func;
    qts_pkg::cmd_t                      decoded;

    assign func = s_tdata[qts_pkg::FUNC_W-1:0];

    always_comb begin
        decoded.value = s_tdata[qts_pkg::FUNC_W +: qts_pkg::DATA_WIDTH];
        case (func)
            qts_pkg::FUNC_INSERT: decoded.op = qts_pkg::OP_INSERT;
            qts_pkg::FUNC_REMOVE: decoded.op = qts_pkg::OP_REMOVE;
            default:              decoded.op = qts_pkg::OP_SIZE;
        endcase
    end

    assign s_tready  = (cnt_reg != qts_pkg::CMDQ_CNT_W'(qts_pkg::CMDQ_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = entry_reg[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

`default_nettype wire

[sv/qts_back.sv]
// ----------------------------------------------------------------------------
// Queue from two stacks: back part
// Executes commands on the insertion and deletion stores, runs the element
// transfer between them and holds the result register of the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module qts_back (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [qts_pkg::LIMIT_W-1:0] stack_limit,
    input  wire logic                        cmd_valid,
    output logic                             cmd_ready,
    input  wire qts_pkg::cmd_t               cmd,
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output qts_pkg::result_t                 res
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_XFER = 3'b010,
        ST_POP  = 3'b100
    } state_t;

    state_t                              state_reg, state_next;
    logic [qts_pkg::FILL_W-1:0]          ifill_reg, ifill_next;
    logic [qts_pkg::FILL_W-1:0]          dfill_reg, dfill_next;
    logic [qts_pkg::FILL_W-1:0]          rd_cnt_reg, rd_cnt_next;
    logic                                pend_reg, pend_next;
    logic [qts_pkg::ADDR_W-1:0]          widx_reg, widx_next;
    logic                                res_valid_reg, res_valid_next;
    qts_pkg::op_t                        op_reg, op_next;
    logic [qts_pkg::DATA_WIDTH-1:0]      value_reg, value_next;
    qts_pkg::result_t                    res_reg, res_next;

    logic [qts_pkg::FILL_W-1:0]          lim;
    logic                                take;
    logic [qts_pkg::FILL_W-1:0]          ins_top;
    logic [qts_pkg::FILL_W-1:0]          del_top;

    logic                                ins_we;
    logic [qts_pkg::ADDR_W-1:0]          ins_waddr, ins_raddr;
    logic [qts_pkg::DATA_WIDTH-1:0]      ins_wdata, ins_rdata;
    logic                                del_we;
    logic [qts_pkg::ADDR_W-1:0]          del_waddr, del_raddr;
    logic [qts_pkg::DATA_WIDTH-1:0]      del_wdata, del_rdata;

    qts_ram #(
        .WIDTH (qts_pkg::DATA_WIDTH),
        .DEPTH (qts_pkg::DEPTH)
    ) u_ins_ram (
        .aclk  (aclk),
        .we    (ins_we),
        .waddr (ins_waddr),
        .wdata (ins_wdata),
        .raddr (ins_raddr),
        .rdata (ins_rdata)
    );

    qts_ram #(
        .WIDTH (qts_pkg::DATA_WIDTH),
        .DEPTH (qts_pkg::DEPTH)
    ) u_del_ram (
        .aclk  (aclk),
        .we    (del_we),
        .waddr (del_waddr),
        .wdata (del_wdata),
        .raddr (del_raddr),
        .rdata (del_rdata)
    );

    always_comb begin
        if (stack_limit == '0) begin
            lim = qts_pkg::FILL_W'(1);
        end else if (int'(stack_limit) > qts_pkg::DEPTH) begin
            lim = qts_pkg::FILL_W'(qts_pkg::DEPTH);
        end else begin
            lim = qts_pkg::FILL_W'(stack_limit);
        end
    end

    assign cmd_ready = (state_reg == ST_IDLE) && (!res_valid_reg || res_ready);
    assign take      = cmd_valid && cmd_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign ins_top   = ifill_reg - qts_pkg::FILL_W'(1) - rd_cnt_reg;
    assign del_top   = dfill_reg - qts_pkg::FILL_W'(1);

    always_comb begin
        state_next     = state_reg;
        ifill_next     = ifill_reg;
        dfill_next     = dfill_reg;
        rd_cnt_next    = rd_cnt_reg;
        pend_next      = 1'b0;
        widx_next      = widx_reg;
        op_next        = op_reg;
        value_next     = value_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !res_ready;

        ins_we    = 1'b0;
        ins_waddr = ifill_reg[qts_pkg::ADDR_W-1:0];
        ins_wdata = cmd.value;
        ins_raddr = ins_top[qts_pkg::ADDR_W-1:0];
        del_we    = pend_reg;
        del_waddr = widx_reg;
        del_wdata = ins_rdata;
        del_raddr = del_top[qts_pkg::ADDR_W-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    res_next.status = qts_pkg::STATUS_OK;
                    res_next.value  = '0;
                    res_next.count  = qts_pkg::COUNT_W'(ifill_reg)
                                    + qts_pkg::COUNT_W'(dfill_reg);
                    case (cmd.op)
                        qts_pkg::OP_INSERT: begin
                            if (ifill_reg >= lim) begin
                                if (dfill_reg == '0) begin
                                    op_next     = qts_pkg::OP_INSERT;
                                    value_next  = cmd.value;
                                    rd_cnt_next = '0;
                                    state_next  = ST_XFER;
                                end else begin
                                    res_next.status = qts_pkg::STATUS_OVERFLOW;
                                    res_valid_next  = 1'b1;
                                end
                            end else begin
                                ins_we         = 1'b1;
                                ifill_next     = ifill_reg + qts_pkg::FILL_W'(1);
                                res_next.count = qts_pkg::COUNT_W'(ifill_reg)
                                               + qts_pkg::COUNT_W'(dfill_reg)
                                               + qts_pkg::COUNT_W'(1);
                                res_valid_next = 1'b1;
                            end
                        end
                        qts_pkg::OP_REMOVE: begin
                            if (ifill_reg == '0 && dfill_reg == '0) begin
                                res_next.status = qts_pkg::STATUS_UNDERFLOW;
                                res_valid_next  = 1'b1;
                            end else if (dfill_reg == '0) begin
                                op_next     = qts_pkg::OP_REMOVE;
                                rd_cnt_next = '0;
                                state_next  = ST_XFER;
                            end else begin
                                dfill_next = del_top;
                                state_next = ST_POP;
                            end
                        end
                        default: begin
                            res_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_XFER: begin
                if (rd_cnt_reg < ifill_reg) begin
                    rd_cnt_next = rd_cnt_reg + qts_pkg::FILL_W'(1);
                    pend_next   = 1'b1;
                    widx_next   = rd_cnt_reg[qts_pkg::ADDR_W-1:0];
                end else if (!pend_reg) begin
                    if (op_reg == qts_pkg::OP_INSERT) begin
                        ins_we          = 1'b1;
                        ins_waddr       = '0;
                        ins_wdata       = value_reg;
                        ifill_next      = qts_pkg::FILL_W'(1);
                        dfill_next      = ifill_reg;
                        res_next.status = qts_pkg::STATUS_OK;
                        res_next.value  = '0;
                        res_next.count  = qts_pkg::COUNT_W'(ifill_reg)
                                        + qts_pkg::COUNT_W'(1);
                        res_valid_next  = 1'b1;
                        state_next      = ST_IDLE;
                    end else begin
                        del_raddr  = ifill_reg[qts_pkg::ADDR_W-1:0] - qts_pkg::ADDR_W'(1);
                        dfill_next = ifill_reg - qts_pkg::FILL_W'(1);
                        ifill_next = '0;
                        state_next = ST_POP;
                    end
                end
            end
            ST_POP: begin
                res_next.status = qts_pkg::STATUS_OK;
                res_next.value  = del_rdata;
                res_next.count  = qts_pkg::COUNT_W'(ifill_reg)
                                + qts_pkg::COUNT_W'(dfill_reg);
                res_valid_next  = 1'b1;
                state_next      = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ifill_reg     <= '0;
            dfill_reg     <= '0;
            rd_cnt_reg    <= '0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ifill_reg     <= ifill_next;
            dfill_reg     <= dfill_next;
            rd_cnt_reg    <= rd_cnt_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        widx_reg  <= widx_next;
        op_reg    <= op_next;
        value_reg <= value_next;
        res_reg   <= res_next;
    end

endmodule

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Queue from two stacks: testbench
// Drives insert, remove and size query transactions into the block, keeps its
// own copy of the two stacks to work out each result, and compares every
// output transaction field by field in order. The stack limit is written
// over APB between phases, including the out-of-range settings, and both
// stream sides are throttled at random, with one long receiver hold-off.
// ----------------------------------------------------------------------------

module testbench;

    import qts_pkg::*;

    localparam logic [FUNC_W-1:0]     FUNC_SPARE  = 2'd3;
    localparam logic [CFG_ADDR_W-1:0] LIMIT_ADDR  = CFG_ADDR_W'(4 * REG_STACK_LIMIT);
    localparam int                    SETTLE_CYCLES = 24;
    localparam int                    HOLD_CYCLES   = 300;
    localparam int                    CYCLE_LIMIT   = 400000;
    localparam int                    PRINT_CAP     = 50;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    // Fields from bit 0: func, value_in.
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // Fields from bit 0: status, value_out, count.
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0]  paddr    = '0;
    logic [CFG_DATA_W-1:0]  pwdata   = '0;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;

    logic [DATA_WIDTH-1:0]  ins_stack [DEPTH];
    logic [DATA_WIDTH-1:0]  del_stack [DEPTH];
    int unsigned            ins_fill  = 0;
    int unsigned            del_fill  = 0;
    logic [LIMIT_W-1:0]     limit_reg = LIMIT_RESET;

    result_t                pending_results [$];
    int                     mismatch_count = 0;
    int                     cycle_count    = 0;
    int                     send_idle_pct  = 0;
    int                     recv_idle_pct  = 0;
    int                     hold_request   = 0;
    int                     hold_granted   = 0;
    int                     hold_left      = 0;

    queue_from_two_stacks uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (hold_request != hold_granted) begin
            hold_granted <= hold_request;
            hold_left    <= HOLD_CYCLES;
            m_tready     <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < PRINT_CAP)
            $display("MISMATCH at %0t: %s: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata);
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing expected", got.value, '0);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                if (got.value !== want.value)
                    report_mismatch("value_out", got.value, want.value);
                if (got.count !== want.count)
                    report_mismatch("count", 32'(got.count), 32'(want.count));
            end
        end
    end

    function automatic void move_across();
        int unsigned n;
        n = (ins_fill > DEPTH) ? DEPTH : ins_fill;
        for (int i = 0; i < n; i++)
            del_stack[i] = ins_stack[n - 1 - i];
        del_fill = n;
        ins_fill = 0;
    endfunction

    function automatic result_t predict_queue_op(input logic [FUNC_W-1:0] func,
                                                 input logic [DATA_WIDTH-1:0] value);
        result_t     r;
        int unsigned lim;
        r        = '0;
        r.status = STATUS_OK;
        if (limit_reg == 0)
            lim = 1;
        else if (limit_reg > DEPTH)
            lim = DEPTH;
        else
            lim = limit_reg;
        case (func)
            FUNC_INSERT: begin
                if (ins_fill >= lim) begin
                    if (del_fill == 0) begin
                        move_across();
                        ins_stack[0] = value;
                        ins_fill     = 1;
                    end else begin
                        r.status = STATUS_OVERFLOW;
                    end
                end else begin
                    ins_stack[ins_fill] = value;
                    ins_fill++;
                end
            end
            FUNC_REMOVE: begin
                if (ins_fill == 0 && del_fill == 0) begin
                    r.status = STATUS_UNDERFLOW;
                end else begin
                    if (del_fill == 0)
                        move_across();
                    del_fill--;
                    r.value = del_stack[del_fill];
                end
            end
            default: begin
            end
        endcase
        r.count = COUNT_W'(ins_fill + del_fill);
        return r;
    endfunction

    task automatic send_op(input logic [FUNC_W-1:0] func, input logic [DATA_WIDTH-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'({value, func});
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        pending_results.push_back(predict_queue_op(func, value));
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_stack_limit(input logic [LIMIT_W-1:0] lim);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LIMIT_ADDR;
        pwdata  <= CFG_DATA_W'(lim);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        limit_reg = lim;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        if (prdata[LIMIT_W-1:0] !== lim)
            report_mismatch("stack_limit read-back", prdata, CFG_DATA_W'(lim));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic run_random_items(input int n);
        int                    insert_pct;
        int                    pick;
        logic [FUNC_W-1:0]     func;
        logic [DATA_WIDTH-1:0] value;
        insert_pct = 50;
        for (int i = 0; i < n; i++) begin
            if (i % 25 == 0) begin
                case ($urandom_range(2))
                    0:       insert_pct = 75;
                    1:       insert_pct = 25;
                    default: insert_pct = 50;
                endcase
            end
            pick = $urandom_range(99);
            if (pick < 4)
                func = FUNC_SIZE;
            else if (pick < 8)
                func = FUNC_SPARE;
            else if ($urandom_range(99) < insert_pct)
                func = FUNC_INSERT;
            else
                func = FUNC_REMOVE;
            case ($urandom_range(15))
                0:       value = 32'h8000_0000;
                1:       value = 32'h7fff_ffff;
                2:       value = '0;
                3:       value = '1;
                default: value = $urandom();
            endcase
            send_op(func, value);
        end
    endtask

    task automatic test_reset_state();
        send_op(FUNC_SIZE, 32'h1234_5678);
        send_op(FUNC_SPARE, 32'hffff_ffff);
        send_op(FUNC_REMOVE, 32'h0000_0000);
        wait_for_drain();
    endtask

    task automatic test_directed_ops();
        write_stack_limit(5'd31);
        send_op(FUNC_INSERT, 32'h8000_0000);
        send_op(FUNC_INSERT, 32'h7fff_ffff);
        send_op(FUNC_INSERT, 32'hffff_ffff);
        send_op(FUNC_INSERT, 32'h0000_0000);
        send_op(FUNC_SIZE, 32'h0000_0000);
        repeat (5) send_op(FUNC_REMOVE, 32'hffff_ffff);
        wait_for_drain();
        // A limit of zero behaves as a limit of one.
        write_stack_limit(5'd0);
        send_op(FUNC_INSERT, 32'haaaa_aaaa);
        send_op(FUNC_INSERT, 32'h5555_5555);
        send_op(FUNC_INSERT, 32'h0000_0001);
        repeat (3) send_op(FUNC_REMOVE, 32'h0000_0000);
        wait_for_drain();
    endtask

    task automatic test_limit_lowered();
        write_stack_limit(5'd17);
        send_op(FUNC_INSERT, 32'hdead_beef);
        send_op(FUNC_INSERT, 32'h0bad_cafe);
        send_op(FUNC_INSERT, 32'h1357_9bdf);
        wait_for_drain();
        // The insertion stack now holds more than the new limit allows.
        write_stack_limit(5'd1);
        send_op(FUNC_INSERT, 32'h2468_ace0);
        send_op(FUNC_REMOVE, 32'h0000_0000);
        wait_for_drain();
    endtask

    task automatic test_random_traffic(input int sender_pct, input int receiver_pct);
        logic [LIMIT_W-1:0] lim;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        for (int seg = 0; seg < 4; seg++) begin
            case (seg)
                0:       lim = LIMIT_W'($urandom_range(1, 4));
                1:       lim = LIMIT_W'(16);
                2:       lim = LIMIT_W'($urandom_range(5, 15));
                default: lim = LIMIT_W'($urandom_range(0, 31));
            endcase
            write_stack_limit(lim);
            run_random_items(100);
            wait_for_drain();
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_stack_limit(5'd16);
        hold_request++;
        run_random_items(40);
        wait_for_drain();
        run_random_items(80);
        wait_for_drain();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_idle_pct = 33;
        recv_idle_pct = 62;
        test_reset_state();
        test_directed_ops();
        test_limit_lowered();
        test_random_traffic(33, 62);
        test_random_traffic(62, 33);
        test_random_traffic(0, 0);
        test_backpressure();
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[sim.f]
sv/qts_pkg.sv
sv/qts_ram.sv
sv/qts_front.sv
sv/qts_back.sv
sv/queue_from_two_stacks.sv
bench/testbench.sv
